// ===== hdl/assert_macros.svh =====
// Assertion helpers used by urxf_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// A condition that, once seen, is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/urxf_pkg.sv =====
package urxf_pkg;

  // Decoded operation of one input word.
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_BULK  = 3'd2,
    OP_LINE  = 3'd3,
    OP_FLUSH = 3'd4,
    OP_NOP   = 3'd5
  } op_t;

  // Raw kind codes on the input port.
  localparam logic [2:0] KIND_ARRIVE = 3'd0;
  localparam logic [2:0] KIND_READ   = 3'd1;
  localparam logic [2:0] KIND_BULK   = 3'd2;
  localparam logic [2:0] KIND_LINE   = 3'd3;
  localparam logic [2:0] KIND_FLUSH  = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NA       = 2'd1,
    ST_DISABLED = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_ENABLE      = 1'b0,
    REG_BUFFER_SIZE = 1'b1
  } cfg_reg_t;

  // States of the back-end sequencer.
  typedef enum logic [0:0] {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_t;

  // Reset value of the size register.
  localparam logic [6:0] BUF_SIZE_RESET = 7'd64;

  // Command queue between the front and the back.
  localparam int QD      = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // Classified command word.
  typedef struct packed {
    op_t        op;
    logic [7:0] rx_data;
    logic [7:0] count;
    logic [7:0] delimiter;
    logic [9:0] capacity;
  } cmd_t;

  // Configuration write as seen by the back end.
  typedef struct packed {
    logic       we;
    cfg_reg_t   index;
    logic [6:0] data;
  } cfg_write_t;

endpackage

// ===== hdl/uart_rx_ring_fifo.sv =====
// Receive ring FIFO. A single-result item goes through the front register, the command
// queue, the pending stage and the output register, and busy stays high until the result
// is in the output register. A bulk read of N bytes gives one byte per cycle from the
// ring memory once its run starts; results cannot be stalled.
// Synchronous reset clears pointers, fill level, drop count and line index, and
// sets enable to 0 and the size to 64; ring contents are not cleared.
module uart_rx_ring_fifo
  import urxf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  rx_data,
  input  logic [7:0]  count,
  input  logic [7:0]  delimiter,
  input  logic [9:0]  capacity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [7:0]  data,
  output logic        has_data,
  output logic [9:0]  slot,
  output logic        line_done,
  output logic [9:0]  line_length,
  output logic        dropped,
  output logic [6:0]  fill_level,
  output logic [31:0] overflow_count,
  output logic        last
);

  logic       accept;
  logic       f_valid;
  cmd_t       f_cmd;
  logic       f_ready;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_ready;
  logic       back_busy;
  cfg_write_t cfg;

  // One item in flight from the front to the output register.
  assign busy      = f_valid || q_valid || back_busy;
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  assign cfg.we    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_reg_t'(cfg_index);
  assign cfg.data  = cfg_data;

  urxf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .rx_data   (rx_data),
    .count     (count),
    .delimiter (delimiter),
    .capacity  (capacity),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  urxf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  urxf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd_valid      (q_valid),
    .cmd            (q_cmd),
    .cmd_ready      (q_ready),
    .back_busy      (back_busy),
    .strobe         (strobe),
    .status         (status),
    .data           (data),
    .has_data       (has_data),
    .slot           (slot),
    .line_done      (line_done),
    .line_length    (line_length),
    .dropped        (dropped),
    .fill_level     (fill_level),
    .overflow_count (overflow_count),
    .last           (last)
  );

endmodule

// ===== hdl/urxf_front.sv =====
module urxf_front
  import urxf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] kind,
  input  logic [7:0] rx_data,
  input  logic [7:0] count,
  input  logic [7:0] delimiter,
  input  logic [9:0] capacity,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  cmd_t decoded;

  // Classify the raw kind into an operation.
  always_comb begin
    decoded.rx_data   = rx_data;
    decoded.count     = count;
    decoded.delimiter = delimiter;
    decoded.capacity  = capacity;
    case (kind)
      KIND_ARRIVE: decoded.op = OP_PUSH;
      KIND_READ:   decoded.op = OP_POP;
      KIND_BULK:   decoded.op = OP_BULK;
      KIND_LINE:   decoded.op = OP_LINE;
      KIND_FLUSH:  decoded.op = OP_FLUSH;
      default:     decoded.op = OP_NOP;
    endcase
  end

  // Hold the classified word until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= decoded;
    end
  end

endmodule

// ===== hdl/urxf_queue.sv =====
module urxf_queue
  import urxf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t in_cmd,
  output logic in_ready,
  output logic out_valid,
  output cmd_t out_cmd,
  input  logic out_ready
);

  cmd_t              entries [QD];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready  = (fill != QCNT_W'(QD));
  assign out_valid = (fill != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== hdl/urxf_back.sv =====
`include "assert_macros.svh"

module urxf_back
  import urxf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_write_t  cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  output logic        back_busy,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [7:0]  data,
  output logic        has_data,
  output logic [9:0]  slot,
  output logic        line_done,
  output logic [9:0]  line_length,
  output logic        dropped,
  output logic [6:0]  fill_level,
  output logic [31:0] overflow_count,
  output logic        last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  // Fields of a result on its way to the output register.
  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       has_data;
    logic       from_mem;
    logic       line_pop;
    logic [7:0] delimiter;
    logic [9:0] slot;
    logic       line_done;
    logic [9:0] line_length;
    logic       dropped;
    logic       last;
  } pend_t;

  // Configuration and ring state.
  logic          enable;
  logic [6:0]    buf_size;
  logic [6:0]    ring_size;
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [FW-1:0] fill;
  logic [31:0]   drops;
  logic [9:0]    line_idx;
  logic [FW-1:0] remain;
  logic [7:0]    ring [DEPTH];
  logic [7:0]    mem_q;

  back_state_t   state;
  back_state_t   state_next;
  logic          take;
  logic          run_step;

  logic [AW-1:0] wptr_next;
  logic [AW-1:0] rptr_next;
  logic [FW-1:0] fill_next;
  logic [31:0]   drops_next;
  logic [FW-1:0] remain_next;
  logic          mem_we;
  logic          mem_re;
  logic          line_clr;
  logic          ld_pend;
  pend_t         pend_in;

  logic          p_valid;
  pend_t         pend;
  logic [FW-1:0] p_fill;
  logic [31:0]   p_drops;

  pend_t         res;
  logic [9:0]    line_idx_next;
  logic          line_upd;

  assign ring_size = (buf_size > 7'(DEPTH)) ? 7'(DEPTH) : buf_size;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [6:0] rs);
    logic [6:0] n;
    n = 7'(p) + 7'd1;
    return (n >= rs) ? '0 : n[AW-1:0];
  endfunction

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (take && cmd.op == OP_BULK && enable && cmd.count != 8'd0 &&
            cmd.count <= 8'(fill)) begin
          state_next = B_RUN;
        end
      end
      B_RUN: begin
        if (remain == FW'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    case (state)
      B_IDLE: begin
        cmd_ready = !p_valid;
        run_step  = 1'b0;
      end
      B_RUN: begin
        cmd_ready = 1'b0;
        run_step  = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
        run_step  = 1'b0;
      end
    endcase
  end

  assign take      = cmd_valid && cmd_ready;
  assign back_busy = (state != B_IDLE) || p_valid;

  // Execute a command or one step of a bulk run.
  always_comb begin
    wptr_next   = wptr;
    rptr_next   = rptr;
    fill_next   = fill;
    drops_next  = drops;
    remain_next = remain;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    line_clr    = 1'b0;
    ld_pend     = 1'b0;
    pend_in     = '0;
    pend_in.status = ST_OK;
    pend_in.last   = 1'b1;
    if (take) begin
      ld_pend = 1'b1;
      case (cmd.op)
        OP_FLUSH: begin
          wptr_next = '0;
          rptr_next = '0;
          fill_next = '0;
        end
        OP_PUSH: begin
          if (!enable) begin
            pend_in.status = ST_DISABLED;
          end else if (7'(fill) < ring_size) begin
            mem_we    = 1'b1;
            wptr_next = adv(wptr, ring_size);
            fill_next = fill + 1'b1;
          end else begin
            drops_next      = drops + 32'd1;
            pend_in.dropped = 1'b1;
          end
        end
        OP_POP: begin
          if (!enable) begin
            pend_in.status = ST_DISABLED;
          end else if (fill == '0) begin
            pend_in.status = ST_NA;
          end else begin
            mem_re            = 1'b1;
            rptr_next         = adv(rptr, ring_size);
            fill_next         = fill - 1'b1;
            pend_in.has_data  = 1'b1;
            pend_in.from_mem  = 1'b1;
          end
        end
        OP_BULK: begin
          if (!enable) begin
            pend_in.status = ST_DISABLED;
          end else if (cmd.count > 8'(fill)) begin
            pend_in.status = ST_NA;
          end else if (cmd.count != 8'd0) begin
            // The run itself produces the results.
            ld_pend     = 1'b0;
            remain_next = FW'(cmd.count);
          end
        end
        OP_LINE: begin
          if (!enable) begin
            pend_in.status = ST_DISABLED;
          end else if (fill == '0) begin
            pend_in.status = ST_NA;
          end else if (line_idx < cmd.capacity) begin
            mem_re            = 1'b1;
            rptr_next         = adv(rptr, ring_size);
            fill_next         = fill - 1'b1;
            pend_in.from_mem  = 1'b1;
            pend_in.line_pop  = 1'b1;
            pend_in.delimiter = cmd.delimiter;
            pend_in.slot      = line_idx;
          end else begin
            // Line is full: close it without popping.
            line_clr            = 1'b1;
            pend_in.line_done   = 1'b1;
            pend_in.line_length = line_idx;
          end
        end
        default: begin
        end
      endcase
    end else if (run_step) begin
      ld_pend          = 1'b1;
      mem_re           = 1'b1;
      rptr_next        = adv(rptr, ring_size);
      fill_next        = fill - 1'b1;
      remain_next      = remain - 1'b1;
      pend_in.has_data = 1'b1;
      pend_in.from_mem = 1'b1;
      pend_in.last     = (remain == FW'(1));
    end
  end

  // Resolve the pending result with the byte read from the ring.
  always_comb begin
    res           = pend;
    line_upd      = 1'b0;
    line_idx_next = line_idx;
    if (pend.from_mem) begin
      res.data = mem_q;
    end
    if (pend.line_pop) begin
      line_upd = 1'b1;
      if (mem_q == pend.delimiter) begin
        res.status      = ST_OK;
        res.data        = 8'd0;
        res.has_data    = 1'b0;
        res.slot        = 10'd0;
        res.line_done   = 1'b1;
        res.line_length = pend.slot;
        line_idx_next   = 10'd0;
      end else begin
        res.status    = ST_NA;
        res.has_data  = 1'b1;
        line_idx_next = pend.slot + 10'd1;
      end
    end
  end

  // Configuration and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      enable   <= 1'b0;
      buf_size <= BUF_SIZE_RESET;
      wptr     <= '0;
      rptr     <= '0;
      fill     <= '0;
      drops    <= '0;
      line_idx <= '0;
      remain   <= '0;
      p_valid  <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state   <= state_next;
      remain  <= remain_next;
      p_valid <= ld_pend;
      strobe  <= p_valid;
      if (cfg.we) begin
        // Any register write reinstalls the ring.
        if (cfg.index == REG_ENABLE) begin
          enable <= cfg.data[0];
        end else begin
          buf_size <= cfg.data;
        end
        wptr  <= '0;
        rptr  <= '0;
        fill  <= '0;
        drops <= '0;
      end else begin
        wptr  <= wptr_next;
        rptr  <= rptr_next;
        fill  <= fill_next;
        drops <= drops_next;
      end
      if (line_clr) begin
        line_idx <= '0;
      end else if (p_valid && line_upd) begin
        line_idx <= line_idx_next;
      end
    end
  end

  // Pending result stage.
  always_ff @(posedge clk) begin
    if (ld_pend) begin
      pend    <= pend_in;
      p_fill  <= fill_next;
      p_drops <= drops_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (p_valid) begin
      status         <= res.status;
      data           <= res.data;
      has_data       <= res.has_data;
      slot           <= res.slot;
      line_done      <= res.line_done;
      line_length    <= res.line_length;
      dropped        <= res.dropped;
      fill_level     <= 7'(p_fill);
      overflow_count <= p_drops;
      last           <= res.last;
    end
  end

  // Ring memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wptr] <= cmd.rx_data;
    end
    if (mem_re) begin
      mem_q <= ring[rptr];
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, 7'(fill) <= ring_size || fill == '0)
  `ASSERT_NEXT(a_pend_shows, clk, rst, p_valid, strobe)
  `ASSERT_IMPLIES(a_run_has_bytes, clk, rst, state == B_RUN, remain != '0 && fill != '0)

endmodule
